FILE: rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared definitions for the text console writer
// Geometry, field widths, request and character codes, and the control
// structures that pass between the sequencer and the sweep engine.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int TAB_SPACES = 4;

   localparam int CELL_COUNT = ROWS * COLUMNS;
   localparam int COPY_COUNT = (ROWS - 1) * COLUMNS;

   localparam int COL_W   = 7;
   localparam int ROW_W   = 5;
   localparam int POS_W   = 12;
   localparam int CELL_W  = 16;
   localparam int COLOR_W = 8;
   localparam int CHAR_W  = 8;
   localparam int TYPE_W  = 3;
   localparam int CADDR_W = 11;
   localparam int ADDR_W  = $clog2(CELL_COUNT);
   localparam int SWEEP_W = $clog2(CELL_COUNT + 1);
   localparam int TAB_W   = $clog2(TAB_SPACES + 1);

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_USED_W = COL_W + ROW_W + POS_W + CELL_W + 1;

   // Request kinds
   localparam logic [TYPE_W-1:0] REQ_PUT_CHAR = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_LEFT     = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_RIGHT    = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_CLEAR    = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_READ     = 3'd4;

   // Character codes with special handling
   localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_BS      = 8'h08;
   localparam logic [CHAR_W-1:0] CHAR_TAB     = 8'h09;
   localparam logic [CHAR_W-1:0] CHAR_NL      = 8'h0A;
   localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;

   // Configuration register indexes
   localparam logic REG_TEXT_COLOR    = 1'b0;
   localparam logic REG_PROMPT_LENGTH = 1'b1;

   localparam logic [COLOR_W-1:0] TEXT_COLOR_RESET    = 8'd63;
   localparam logic [COL_W-1:0]   PROMPT_LENGTH_RESET = 7'd0;

   typedef struct packed {
      logic start;
      logic copy;
   } sweep_ctrl_type;

   typedef struct packed {
      logic              busy;
      logic              done;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic              wr_copy;
   } sweep_stat_type;

endpackage

FILE: rtl/core/tcw_ram.sv
// ----------------------------------------------------------------------------
// tcw_ram: generic single-clock RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/tcw_sweep.sv
// ----------------------------------------------------------------------------
// tcw_sweep: cell store sweep engine
// Walks the whole store once, either filling every cell with a blank or
// moving each row up by one and blanking the bottom row.
// ----------------------------------------------------------------------------
module tcw_sweep
   import tcw_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  sweep_ctrl_type ctrl,
   output sweep_stat_type stat
);

   logic               active_ff, active_in;
   logic               copy_ff, copy_in;
   logic [SWEEP_W-1:0] cnt_ff, cnt_in;
   logic [SWEEP_W-1:0] wr_idx;

   always_comb begin
      active_in = active_ff;
      copy_in   = copy_ff;
      cnt_in    = cnt_ff;
      if (ctrl.start) begin
         active_in = 1'b1;
         copy_in   = ctrl.copy;
         cnt_in    = '0;
      end else if (active_ff) begin
         if (cnt_ff == SWEEP_W'(CELL_COUNT)) begin
            active_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   // Each write lands in the cycle after its read so that copied data has arrived.
   assign wr_idx = cnt_ff - 1'b1;

   always_comb begin
      stat.busy    = active_ff;
      stat.done    = active_ff && (cnt_ff == SWEEP_W'(CELL_COUNT));
      stat.rd_en   = active_ff && copy_ff && (cnt_ff < SWEEP_W'(COPY_COUNT));
      stat.rd_addr = ADDR_W'(cnt_ff + SWEEP_W'(COLUMNS));
      stat.wr_en   = active_ff && (cnt_ff != '0);
      stat.wr_addr = ADDR_W'(wr_idx);
      stat.wr_copy = copy_ff && (wr_idx < SWEEP_W'(COPY_COUNT));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      copy_ff <= copy_in;
      cnt_ff  <= cnt_in;
   end

endmodule

FILE: rtl/core/tcw_lin_addr.sv
// ----------------------------------------------------------------------------
// tcw_lin_addr: linear cell position
// Turns a row and column into row times the line length plus column.
// ----------------------------------------------------------------------------
module tcw_lin_addr
   import tcw_pkg::*;
(
   input  logic [ROW_W-1:0] row,
   input  logic [COL_W-1:0] col,
   output logic [POS_W-1:0] pos
);

   assign pos = POS_W'(POS_W'(row) * POS_W'(COLUMNS)) + POS_W'(col);

endmodule

FILE: rtl/core/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer: text-mode console with cursor and cell store
// Top level: request sequencer, cursor, configuration and result register.
// ----------------------------------------------------------------------------
// The block keeps a 25 x 80 store of 16-bit cells (attribute in the high byte,
// character in the low byte) and a cursor. Requests arrive on the req_ stream
// channel with the request kind in req_tuser; each request yields exactly one
// result transaction on the rsp_ channel carrying the cursor, its linear
// position, a read-back cell and a scroll flag.
// The block takes one request at a time. On its way to the result register an
// arrow key or unknown request goes straight to the done state, a read passes
// the read state, a printable character, newline, backspace or NUL the wrap
// and act states, and a tab a wrap check and a cell write for each of its
// four blanks. Scrolling and clear screen walk the store through the single
// write port of the cell RAM, one cell a cycle.
// After reset the store is filled with blanks by the same sweep: req_tready
// stays low until it ends; configuration writes are taken throughout.
// The result register decouples the two sides: a new request is accepted while
// a result waits, and the block holds its next result until rsp_tready frees
// the register.
// ----------------------------------------------------------------------------
module text_console_writer
   import tcw_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // char_code[7:0], cell_address[18:8]
   input  logic [TYPE_W-1:0]     req_tuser,   // req_type[2:0]
   // Result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // cursor_x[6:0], cursor_y[11:7],
                                              // cursor_pos[23:12], read_cell[39:24],
                                              // scrolled[40]
   // Configuration port
   input  logic                  csr_we,
   input  logic                  csr_index,
   input  logic [COLOR_W-1:0]    csr_wdata
);

   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_WRAP  = 3'd2;
   localparam logic [2:0] ST_SWEEP = 3'd3;
   localparam logic [2:0] ST_ACT   = 3'd4;
   localparam logic [2:0] ST_READ  = 3'd5;
   localparam logic [2:0] ST_DONE  = 3'd6;

   logic [2:0]            state_ff, state_in;
   logic [COL_W-1:0]      col_ff, col_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [COLOR_W-1:0]    color_ff, color_in;
   logic [COL_W-1:0]      prompt_ff, prompt_in;
   logic                  pending_ff, pending_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  scrolled_ff, scrolled_in;
   logic                  sweep_scroll_ff, sweep_scroll_in;
   logic [CHAR_W-1:0]     char_ff, char_in;
   logic [TAB_W-1:0]      tab_ff, tab_in;
   logic [CELL_W-1:0]     read_cell_ff, read_cell_in;
   logic                  addr_ok_ff, addr_ok_in;
   logic [COLOR_W-1:0]    sweep_color_ff, sweep_color_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic [TYPE_W-1:0]     req_type;
   logic [CHAR_W-1:0]     req_char;
   logic [CADDR_W-1:0]    req_addr;
   logic                  req_accept;

   logic [COL_W-1:0]      wrap_col;
   logic [ROW_W-1:0]      wrap_row;
   logic [COL_W-1:0]      col_sel;
   logic [POS_W-1:0]      lin_pos;
   logic                  bs_allowed;

   logic                  act_wr_en;
   logic [CHAR_W-1:0]     act_wr_char;

   sweep_ctrl_type        sweep_ctrl;
   sweep_stat_type        sweep_stat;

   logic                  ram_wr_en;
   logic [ADDR_W-1:0]     ram_wr_addr;
   logic [CELL_W-1:0]     ram_wr_data;
   logic                  ram_rd_en;
   logic [ADDR_W-1:0]     ram_rd_addr;
   logic [CELL_W-1:0]     ram_rd_data;

   assign req_type   = req_tuser;
   assign req_char   = req_tdata[CHAR_W-1:0];
   assign req_addr   = req_tdata[CHAR_W+CADDR_W-1:CHAR_W];
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;

   // Line wrap ahead of a put character: a cursor one past the last column
   // moves to the start of the next row.
   always_comb begin
      if (col_ff >= COL_W'(COLUMNS)) begin
         wrap_col = '0;
         wrap_row = row_ff + 1'b1;
      end else begin
         wrap_col = col_ff;
         wrap_row = row_ff;
      end
   end

   // Backspace is refused at the left margin and inside the protected prompt.
   assign bs_allowed = (col_ff != '0) && !((prompt_ff != '0) && (col_ff <= prompt_ff));

   // Backspace blanks the cell to the left of the cursor; everything else
   // addresses the cell under the cursor.
   assign col_sel = ((state_ff == ST_ACT) && (char_ff == CHAR_BS)) ? col_ff - 1'b1 : col_ff;

   tcw_lin_addr u_lin_addr (
      .row (row_ff),
      .col (col_sel),
      .pos (lin_pos)
   );

   tcw_sweep u_sweep (
      .clock (clock),
      .reset (reset),
      .ctrl  (sweep_ctrl),
      .stat  (sweep_stat)
   );

   // Sequencer
   always_comb begin
      state_in        = state_ff;
      col_in          = col_ff;
      row_in          = row_ff;
      pending_in      = pending_ff;
      rsp_valid_in    = rsp_valid_ff;
      scrolled_in     = scrolled_ff;
      sweep_scroll_in = sweep_scroll_ff;
      char_in         = char_ff;
      tab_in          = tab_ff;
      read_cell_in    = read_cell_ff;
      addr_ok_in      = addr_ok_ff;
      sweep_color_in  = sweep_color_ff;
      rsp_data_in     = rsp_data_ff;
      sweep_ctrl      = '0;
      act_wr_en       = 1'b0;
      act_wr_char     = BLANK_CHAR;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_INIT: begin
            sweep_ctrl.start = 1'b1;
            sweep_ctrl.copy  = 1'b0;
            sweep_color_in   = color_ff;
            sweep_scroll_in  = 1'b0;
            pending_in       = 1'b0;
            state_in         = ST_SWEEP;
         end
         ST_IDLE: begin
            if (req_accept) begin
               pending_in   = 1'b1;
               scrolled_in  = 1'b0;
               read_cell_in = '0;
               char_in      = req_char;
               tab_in       = '0;
               addr_ok_in   = (req_addr < CADDR_W'(CELL_COUNT));
               unique case (req_type)
                  REQ_PUT_CHAR: begin
                     state_in = ST_WRAP;
                  end
                  REQ_LEFT: begin
                     if (col_ff != '0) begin
                        col_in = col_ff - 1'b1;
                     end
                     state_in = ST_DONE;
                  end
                  REQ_RIGHT: begin
                     if (col_ff != COL_W'(COLUMNS)) begin
                        col_in = col_ff + 1'b1;
                     end
                     state_in = ST_DONE;
                  end
                  REQ_CLEAR: begin
                     col_in           = '0;
                     row_in           = '0;
                     sweep_ctrl.start = 1'b1;
                     sweep_ctrl.copy  = 1'b0;
                     sweep_color_in   = color_ff;
                     sweep_scroll_in  = 1'b0;
                     state_in         = ST_SWEEP;
                  end
                  REQ_READ: begin
                     state_in = ST_READ;
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_WRAP: begin
            col_in = wrap_col;
            if (wrap_row >= ROW_W'(ROWS)) begin
               row_in           = ROW_W'(ROWS - 1);
               scrolled_in      = 1'b1;
               sweep_ctrl.start = 1'b1;
               sweep_ctrl.copy  = 1'b1;
               sweep_color_in   = color_ff;
               sweep_scroll_in  = 1'b1;
               state_in         = ST_SWEEP;
            end else begin
               row_in   = wrap_row;
               state_in = ST_ACT;
            end
         end
         ST_SWEEP: begin
            if (sweep_stat.done) begin
               if (!pending_ff) begin
                  state_in = ST_IDLE;
               end else if (sweep_scroll_ff) begin
                  state_in = ST_ACT;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_ACT: begin
            unique case (char_ff)
               CHAR_NL: begin
                  row_in   = row_ff + 1'b1;
                  col_in   = '0;
                  state_in = ST_DONE;
               end
               CHAR_BS: begin
                  if (bs_allowed) begin
                     col_in      = col_ff - 1'b1;
                     act_wr_en   = 1'b1;
                     act_wr_char = BLANK_CHAR;
                  end
                  state_in = ST_DONE;
               end
               CHAR_NUL: begin
                  state_in = ST_DONE;
               end
               CHAR_TAB: begin
                  act_wr_en   = 1'b1;
                  act_wr_char = BLANK_CHAR;
                  col_in      = col_ff + 1'b1;
                  if (tab_ff == TAB_W'(TAB_SPACES - 1)) begin
                     state_in = ST_DONE;
                  end else begin
                     tab_in   = tab_ff + 1'b1;
                     state_in = ST_WRAP;
                  end
               end
               default: begin
                  act_wr_en   = 1'b1;
                  act_wr_char = char_ff;
                  col_in      = col_ff + 1'b1;
                  state_in    = ST_DONE;
               end
            endcase
         end
         ST_READ: begin
            read_cell_in = addr_ok_ff ? ram_rd_data : '0;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {(RSP_DATA_W - RSP_USED_W)'(0), scrolled_ff, read_cell_ff,
                               lin_pos, row_ff, col_ff};
               pending_in   = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Configuration registers.
   always_comb begin
      color_in  = color_ff;
      prompt_in = prompt_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_TEXT_COLOR:    color_in  = csr_wdata;
            REG_PROMPT_LENGTH: prompt_in = csr_wdata[COL_W-1:0];
            default:           color_in  = color_ff;
         endcase
      end
   end

   // Cell RAM port selection: the sweep engine owns the ports while it runs.
   always_comb begin
      if (sweep_stat.busy) begin
         ram_wr_en   = sweep_stat.wr_en;
         ram_wr_addr = sweep_stat.wr_addr;
         ram_wr_data = sweep_stat.wr_copy ? ram_rd_data : {sweep_color_ff, BLANK_CHAR};
         ram_rd_en   = sweep_stat.rd_en;
         ram_rd_addr = sweep_stat.rd_addr;
      end else begin
         ram_wr_en   = act_wr_en && (row_ff < ROW_W'(ROWS)) && (col_sel < COL_W'(COLUMNS));
         ram_wr_addr = ADDR_W'(lin_pos);
         ram_wr_data = {color_ff, act_wr_char};
         ram_rd_en   = req_accept && (req_type == REQ_READ);
         ram_rd_addr = ADDR_W'(req_addr);
      end
   end

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELL_COUNT)
   ) u_cell_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_INIT;
         col_ff          <= '0;
         row_ff          <= '0;
         color_ff        <= TEXT_COLOR_RESET;
         prompt_ff       <= PROMPT_LENGTH_RESET;
         pending_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         scrolled_ff     <= 1'b0;
         sweep_scroll_ff <= 1'b0;
      end else begin
         state_ff        <= state_in;
         col_ff          <= col_in;
         row_ff          <= row_in;
         color_ff        <= color_in;
         prompt_ff       <= prompt_in;
         pending_ff      <= pending_in;
         rsp_valid_ff    <= rsp_valid_in;
         scrolled_ff     <= scrolled_in;
         sweep_scroll_ff <= sweep_scroll_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff        <= char_in;
      tab_ff         <= tab_in;
      read_cell_ff   <= read_cell_in;
      addr_ok_ff     <= addr_ok_in;
      sweep_color_ff <= sweep_color_in;
      rsp_data_ff    <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

FILE: bench/tb_text_console_writer.sv
// ----------------------------------------------------------------------------
// tb_text_console_writer: self-checking bench for the text console writer
// Streams console requests into the block and keeps its own screen, cursor
// and register copies. Every result is checked field by field against the
// screen copy while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_text_console_writer
   import tcw_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   // Cycles without any accepted transaction before the run is abandoned.
   // The slowest request is a tab that scrolls (a sweep of the store), and
   // the clearing pass after reset is one such sweep, so this leaves ample room.
   localparam int unsigned QUIET_LIMIT   = 20000;
   // Quiet time after the last result, enough for one more sweep of the store.
   localparam int unsigned SETTLE_CYCLES = 5000;
   localparam int unsigned PHASE_COUNT   = 6;
   localparam int unsigned PHASE_ITEMS   = 310;
   localparam int unsigned ADDR_SPAN     = 1 << CADDR_W;
   localparam int unsigned PRINT_CAP     = 100;

   // Request kinds beyond the defined ones run up to the all-ones code.
   localparam logic [TYPE_W-1:0] REQ_KIND_LAST = '1;

   // One request as the stimulus sees it. A held request is not offered until
   // every result owed for earlier requests has been taken.
   typedef struct {
      logic [TYPE_W-1:0]  kind;
      logic [CHAR_W-1:0]  ch;
      logic [CADDR_W-1:0] addr;
      bit                 hold;
   } console_req_type;

   // Result fields, declared so that the lowest field lies in the lowest bits
   // of the packed struct, exactly as they sit in rsp_tdata.
   typedef struct packed {
      logic              scrolled;
      logic [CELL_W-1:0] rd_cell;
      logic [POS_W-1:0]  pos;
      logic [ROW_W-1:0]  y;
      logic [COL_W-1:0]  x;
   } console_status_type;

   typedef enum {ALWAYS_READY, COIN_FLIP, MOSTLY_STALLED, EVERY_EIGHTH} rsp_pace_type;

   logic                  clock;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // char_code[7:0], cell_address[18:8]
   logic [TYPE_W-1:0]     req_tuser  = '0;   // req_type[2:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // cursor_x[6:0], cursor_y[11:7],
                                             // cursor_pos[23:12], read_cell[39:24],
                                             // scrolled[40]
   logic                  csr_we     = 1'b0;
   logic                  csr_index  = REG_TEXT_COLOR;
   logic [COLOR_W-1:0]    csr_wdata  = '0;

   text_console_writer dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      clock = 1'b0;
      #1;
      clock = 1'b1;
      #1;
   end

   // -------------------------------------------------------------------------
   // Screen copy: the cells, the cursor and the two registers as the block
   // should hold them after every request that has been accepted so far.
   // -------------------------------------------------------------------------
   logic [CELL_W-1:0]  screen [CELL_COUNT];
   int unsigned        cur_x;
   int unsigned        cur_y;
   logic [COLOR_W-1:0] attr;
   logic [COL_W-1:0]   guard_cols;

   console_req_type    req_backlog [$];   // requests waiting to be offered
   console_req_type    req_on_wire;       // the request currently offered
   console_status_type status_due [$];    // results owed, oldest first
   console_status_type seen_status;
   console_status_type due_status;
   bit                 hold_armed   = 1'b0;
   int unsigned        error_count  = 0;
   int unsigned        results_seen = 0;
   int unsigned        burst_left   = 0;
   int unsigned        gap_left     = 0;
   int unsigned        pace_left    = 0;
   rsp_pace_type       pace         = ALWAYS_READY;
   bit                 ready_next;
   int unsigned        quiet_cycles = 0;

   function automatic logic [CELL_W-1:0] blank_cell();
      return {attr, BLANK_CHAR};
   endfunction

   function automatic void fill_screen();
      int unsigned i;
      for (i = 0; i < CELL_COUNT; i++)
         screen[i] = blank_cell();
   endfunction

   // Wrap once the cursor stands one past the last column, then scroll up by
   // a single row if the cursor has dropped below the bottom. Returns whether
   // a scroll took place.
   function automatic bit wrap_and_scroll();
      int unsigned i;
      if (cur_x >= COLUMNS) begin
         cur_x = 0;
         cur_y++;
      end
      if (cur_y >= ROWS) begin
         for (i = 0; i < COPY_COUNT; i++)
            screen[i] = screen[i + COLUMNS];
         for (i = COPY_COUNT; i < CELL_COUNT; i++)
            screen[i] = blank_cell();
         cur_y = ROWS - 1;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // Only called straight after a wrap and scroll, so the cursor is on screen.
   function automatic void put_glyph(logic [CHAR_W-1:0] ch);
      screen[cur_y * COLUMNS + cur_x] = {attr, ch};
      cur_x++;
   endfunction

   // Applies one accepted request to the screen copy and returns the result
   // that the block owes for it.
   function automatic console_status_type advance_console(console_req_type r);
      console_status_type s;
      int unsigned        i;
      s = '0;
      case (r.kind)
         REQ_PUT_CHAR: begin
            s.scrolled = wrap_and_scroll();
            case (r.ch)
               CHAR_NL: begin
                  cur_y++;
                  cur_x = 0;
               end
               CHAR_BS: begin
                  // Blocked at the left margin and inside the protected prompt.
                  if (cur_x != 0 && !(guard_cols != 0 && cur_x <= guard_cols)) begin
                     cur_x--;
                     screen[cur_y * COLUMNS + cur_x] = blank_cell();
                  end
               end
               CHAR_NUL: ;
               CHAR_TAB: begin
                  for (i = 0; i < TAB_SPACES; i++) begin
                     if (wrap_and_scroll())
                        s.scrolled = 1'b1;
                     put_glyph(BLANK_CHAR);
                  end
               end
               default: put_glyph(r.ch);
            endcase
         end
         REQ_LEFT: begin
            if (cur_x != 0)
               cur_x--;
         end
         REQ_RIGHT: begin
            if (cur_x != COLUMNS)
               cur_x++;
         end
         REQ_CLEAR: begin
            fill_screen();
            cur_x = 0;
            cur_y = 0;
         end
         REQ_READ: begin
            if (r.addr < CELL_COUNT)
               s.rd_cell = screen[r.addr];
         end
         default: ;
      endcase
      s.x   = COL_W'(cur_x);
      s.y   = ROW_W'(cur_y);
      s.pos = POS_W'(cur_y * COLUMNS + cur_x);
      return s;
   endfunction

   // -------------------------------------------------------------------------
   // Reporting. Every mismatch is counted; only the first hundred are printed
   // so that a badly broken build still gives a readable log.
   // -------------------------------------------------------------------------
   task automatic flag_error(input string msg);
      error_count++;
      if (error_count <= PRINT_CAP)
         $display("ERROR: %s", msg);
   endtask

   task automatic check_field(input string name, input int unsigned got,
                              input int unsigned want);
      if (got != want)
         flag_error($sformatf("result %0d %s: got %0d, expected %0d",
                              results_seen, name, got, want));
   endtask

   // -------------------------------------------------------------------------
   // Request driver. A transaction completes at an edge where tvalid and
   // tready are both high; its result is worked out there and then. The next
   // request is offered in bursts of random length with random gaps between
   // them, and long bursts give stretches with no idling at all.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : request_driver
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            status_due.push_back(advance_console(req_on_wire));
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (req_backlog.size() != 0 &&
                         !(req_backlog[0].hold && status_due.size() != 0)) begin
               req_on_wire = req_backlog.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {{(REQ_DATA_W - CHAR_W - CADDR_W){1'b0}},
                              req_on_wire.addr, req_on_wire.ch};
               req_tuser  <= req_on_wire.kind;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                          : $urandom_range(1, 16);
                  gap_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40)
                                                          : $urandom_range(0, 3);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // Result monitor. Each result transaction is unpacked and compared with the
   // oldest owed result. The ready pattern changes at random intervals between
   // always ready, a coin flip, mostly stalled and one cycle in eight.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : result_monitor
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (status_due.size() == 0) begin
               flag_error($sformatf("result %0d arrived with no request outstanding",
                                    results_seen));
            end else begin
               seen_status = console_status_type'(rsp_tdata[RSP_USED_W-1:0]);
               due_status  = status_due.pop_front();
               check_field("cursor_x",   32'(seen_status.x),        32'(due_status.x));
               check_field("cursor_y",   32'(seen_status.y),        32'(due_status.y));
               check_field("cursor_pos", 32'(seen_status.pos),      32'(due_status.pos));
               check_field("read_cell",  32'(seen_status.rd_cell),  32'(due_status.rd_cell));
               check_field("scrolled",   32'(seen_status.scrolled), 32'(due_status.scrolled));
            end
         end
         if (pace_left == 0) begin
            pace      = rsp_pace_type'($urandom_range(0, 3));
            pace_left = $urandom_range(16, 400);
         end else begin
            pace_left--;
         end
         case (pace)
            ALWAYS_READY:   ready_next = 1'b1;
            COIN_FLIP:      ready_next = 1'($urandom_range(0, 1));
            MOSTLY_STALLED: ready_next = ($urandom_range(0, 3) == 0);
            default:        ready_next = (pace_left % 8 == 0);
         endcase
         rsp_tready <= ready_next;
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: a long stretch with no transaction on either side means the
   // block has hung, so the run is stopped.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : watchdog
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus helpers.
   // -------------------------------------------------------------------------
   task automatic enqueue(input logic [TYPE_W-1:0] kind, input logic [CHAR_W-1:0] ch,
                          input logic [CADDR_W-1:0] addr);
      console_req_type r;
      r.kind     = kind;
      r.ch       = ch;
      r.addr     = addr;
      r.hold     = hold_armed;
      hold_armed = 1'b0;
      req_backlog.push_back(r);
   endtask

   // Looks at the bench state on the falling edge, when everything written at
   // the rising edge has settled, until no request or result is in flight.
   task automatic wait_until_idle();
      do
         @(negedge clock);
      while (req_backlog.size() != 0 || req_tvalid || status_due.size() != 0);
   endtask

   // Register writes happen only while the block is idle, so the copy of the
   // register can change at the same moment without upsetting any prediction.
   task automatic write_csr(input logic idx, input logic [COLOR_W-1:0] value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == REG_TEXT_COLOR)
         attr = value;
      else
         guard_cols = value[COL_W-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   // Queues one short sequence of a single flavour and says how many requests
   // it added. Text runs dominate; the rest push the cursor to the margins and
   // the bottom, read back cells, send tabs or a clear, hit odd request kinds.
   task automatic queue_random_run(output int unsigned added);
      int unsigned choice;
      int unsigned len;
      int unsigned i;
      int unsigned pick;
      logic [CHAR_W-1:0]  ch;
      logic [CADDR_W-1:0] addr;
      logic [TYPE_W-1:0]  kind;
      hold_armed = ($urandom_range(0, 39) == 0);
      choice     = $urandom_range(0, 99);
      if (choice < 45) begin
         // Ordinary text with the occasional control byte mixed in.
         len = $urandom_range(1, 40);
         for (i = 0; i < len; i++) begin
            pick = $urandom_range(0, 39);
            if (pick == 0)
               ch = CHAR_NL;
            else if (pick == 1)
               ch = CHAR_BS;
            else if (pick == 2)
               ch = CHAR_TAB;
            else if (pick == 3)
               ch = CHAR_NUL;
            else
               ch = CHAR_W'($urandom_range(0, 255));
            enqueue(REQ_PUT_CHAR, ch, CADDR_W'($urandom_range(0, ADDR_SPAN - 1)));
         end
      end else if (choice < 49) begin
         // A run of newlines carries the cursor to and past the bottom row.
         len = $urandom_range(1, 26);
         for (i = 0; i < len; i++)
            enqueue(REQ_PUT_CHAR, CHAR_NL, CADDR_W'($urandom_range(0, ADDR_SPAN - 1)));
      end else if (choice < 59) begin
         // Backspaces run into the left margin or the protected prompt.
         len = $urandom_range(1, 12);
         for (i = 0; i < len; i++)
            enqueue(REQ_PUT_CHAR, CHAR_BS, CADDR_W'($urandom_range(0, ADDR_SPAN - 1)));
      end else if (choice < 69) begin
         // Arrow walks; the long ones pin the cursor at either end of the line.
         kind = $urandom_range(0, 1) ? REQ_RIGHT : REQ_LEFT;
         len  = ($urandom_range(0, 3) == 0) ? $urandom_range(40, COLUMNS + 5)
                                           : $urandom_range(1, 8);
         for (i = 0; i < len; i++)
            enqueue(kind, CHAR_W'($urandom_range(0, 255)),
                    CADDR_W'($urandom_range(0, ADDR_SPAN - 1)));
      end else if (choice < 84) begin
         // Read-backs, weighted towards the rows that see the most writing.
         len = $urandom_range(1, 6);
         for (i = 0; i < len; i++) begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
               addr = CADDR_W'($urandom_range(COPY_COUNT - 2 * COLUMNS, CELL_COUNT - 1));
            else if (pick < 6)
               addr = CADDR_W'($urandom_range(0, 3 * COLUMNS - 1));
            else if (pick < 9)
               addr = CADDR_W'($urandom_range(0, CELL_COUNT - 1));
            else
               addr = CADDR_W'($urandom_range(CELL_COUNT, ADDR_SPAN - 1));
            enqueue(REQ_READ, CHAR_W'($urandom_range(0, 255)), addr);
         end
      end else if (choice < 92) begin
         // Tabs, long enough to cross the end of a line.
         len = $urandom_range(1, 24);
         for (i = 0; i < len; i++)
            enqueue(REQ_PUT_CHAR, CHAR_TAB, CADDR_W'($urandom_range(0, ADDR_SPAN - 1)));
      end else if (choice < 97) begin
         len = $urandom_range(1, 3);
         for (i = 0; i < len; i++)
            enqueue(TYPE_W'($urandom_range(REQ_READ + 3'd1, REQ_KIND_LAST)),
                    CHAR_W'($urandom_range(0, 255)),
                    CADDR_W'($urandom_range(0, ADDR_SPAN - 1)));
      end else begin
         enqueue(REQ_CLEAR, CHAR_W'($urandom_range(0, 255)),
                 CADDR_W'($urandom_range(0, ADDR_SPAN - 1)));
      end
      added = len;
      if (choice >= 97)
         added = 1;
   endtask

   // -------------------------------------------------------------------------
   // Test sequence: reset, a directed opening with the reset register values,
   // then several random phases, each under its own colour and prompt setting.
   // -------------------------------------------------------------------------
   initial begin : stimulus
      int unsigned        phase;
      int unsigned        made;
      int unsigned        added;
      logic [COLOR_W-1:0] colour;
      logic [COL_W-1:0]   prompt;

      attr       = TEXT_COLOR_RESET;
      guard_cols = PROMPT_LENGTH_RESET;
      cur_x      = 0;
      cur_y      = 0;
      fill_screen();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed opening. The block is still clearing its store after reset;
      // the driver simply waits for tready.
      enqueue(REQ_READ,     8'h00,    '0);               // blank cell after reset
      enqueue(REQ_PUT_CHAR, 8'h41,    '0);
      enqueue(REQ_PUT_CHAR, 8'hFF,    '0);               // highest character byte
      enqueue(REQ_PUT_CHAR, 8'h01,    '0);
      enqueue(REQ_READ,     8'h00,    CADDR_W'(1));
      enqueue(REQ_PUT_CHAR, CHAR_BS,  '0);               // backspace blanks a cell
      enqueue(REQ_READ,     8'h00,    CADDR_W'(2));
      enqueue(REQ_PUT_CHAR, CHAR_TAB, '0);
      enqueue(REQ_PUT_CHAR, CHAR_NUL, '0);
      enqueue(REQ_LEFT,     8'h00,    '0);
      enqueue(REQ_RIGHT,    8'h00,    '0);
      enqueue(REQ_RIGHT,    8'h00,    '0);
      hold_armed = 1'b1;                                 // sender waits for a full drain
      enqueue(REQ_PUT_CHAR, CHAR_NL,  '0);
      enqueue(REQ_PUT_CHAR, CHAR_BS,  '0);               // blocked at column 0
      enqueue(REQ_LEFT,     8'h00,    '0);               // no move at column 0
      enqueue(REQ_PUT_CHAR, 8'h7E,    '0);
      enqueue(REQ_READ,     8'h00,    CADDR_W'(COLUMNS));
      enqueue(REQ_READ,     8'h00,    CADDR_W'(CELL_COUNT - 1));
      enqueue(REQ_READ,     8'h00,    CADDR_W'(CELL_COUNT)); // first address off screen
      enqueue(REQ_READ,     8'h00,    '1);               // highest address reads zero
      enqueue(REQ_READ + 3'd1, 8'hFF, '1);               // unknown request kinds
      enqueue(REQ_KIND_LAST, 8'h00,   '0);
      enqueue(REQ_CLEAR,    8'h00,    '0);
      enqueue(REQ_READ,     8'h00,    CADDR_W'(COLUMNS));
      enqueue(REQ_PUT_CHAR, 8'h80,    '0);
      wait_until_idle();

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         case (phase)
            0: begin
               colour = '1;
               prompt = '0;
            end
            1: begin
               colour = '0;
               prompt = COL_W'(COLUMNS);                 // every backspace blocked
            end
            2: begin
               colour = COLOR_W'($urandom_range(0, 255));
               prompt = COL_W'($urandom_range(1, COLUMNS - 1));
            end
            3: begin
               colour = TEXT_COLOR_RESET;
               prompt = COL_W'($urandom_range(1, 12));
            end
            default: begin
               colour = COLOR_W'($urandom_range(0, 255));
               prompt = COL_W'($urandom_range(0, COLUMNS));
            end
         endcase
         write_csr(REG_TEXT_COLOR, colour);
         write_csr(REG_PROMPT_LENGTH, {1'b0, prompt});
         @(negedge clock);
         made = 0;
         while (made < PHASE_ITEMS) begin
            queue_random_run(added);
            made += added;
         end
         wait_until_idle();
      end

      // Everything owed has arrived; give a stray result time to show up.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
